/* rtl/bpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg - shared definitions for the buffer pool with congestion
// Command and status codes, register indexes, reset values, FSM type.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // default sizing of the pool
   localparam int MAX_CELLS_DEF       = 256;
   localparam int CONGEST_LEVEL_DEF   = 1;
   localparam int UNCONGEST_LEVEL_DEF = 3;

   // fixed field widths
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 31;
   localparam int SHIFT_W  = 4;
   localparam int REQ_W    = 16;
   localparam int CELL_W   = 17;
   localparam int OFFS_W   = 16;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // commands
   localparam logic [CMD_W-1:0] CMD_CARVE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_CONGESTION = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_BUFFER  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_TOO_FEW    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_POOL_FULL  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_SHIFT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_REQUEST = 2'd3;

   // configuration reset values
   localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_RST  = 4'd2;
   localparam logic [REQ_W-1:0]   CELL_REQUEST_RST = 16'd2048;

   // sequencer states
   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_FILL = 2'b10
   } fsm_type;

endpackage

/* rtl/bpc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/buffer_pool_with_congestion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_with_congestion - FIFO free list of equal buffer cells
// Carves an area into aligned cells, hands them out and takes them back,
// with congestion hysteresis on the free count.
// ----------------------------------------------------------------------------
// Usage:
//   Commands are taken when start is high and busy is low: carve, get or
//   free (address on req_free_address). Each command gives one response,
//   flagged by rsp_strobe for one cycle. A carve that is not rejected for a
//   zero cell size or a base beyond the area answers when its fill ends;
//   every other command answers on the cycle after it is taken. There is no
//   back-pressure: the receiver cannot hold a response off. Get and free can
//   be taken back to back: the free list sits in a single RAM, get reads the
//   head entry, free writes the tail entry. Carve writes one cell address per
//   cycle through the same RAM write port, so it keeps busy high while it
//   writes its cells (at most MAX_CELLS). Configuration (csr_*) must be
//   written only while the block is idle; the block itself does not enforce
//   this. After reset the queue is empty, congestion is clear, cell size is
//   zero, and the registers hold base 0, length 0, shift 2, request 2048.
// ----------------------------------------------------------------------------
module buffer_pool_with_congestion #(
   parameter int MAX_CELLS       = bpc_pkg::MAX_CELLS_DEF,
   parameter int CONGEST_LEVEL   = bpc_pkg::CONGEST_LEVEL_DEF,
   parameter int UNCONGEST_LEVEL = bpc_pkg::UNCONGEST_LEVEL_DEF,
   localparam int IDX_W = $clog2(MAX_CELLS),
   localparam int CNT_W = $clog2(MAX_CELLS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  logic [bpc_pkg::CMD_W-1:0]          req_cmd,
   input  logic [bpc_pkg::ADDR_W-1:0]         req_free_address,
   // response channel
   output logic                               rsp_strobe,
   output logic [bpc_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bpc_pkg::ADDR_W-1:0]         rsp_buf_address,
   output logic [bpc_pkg::CELL_W-1:0]         rsp_buf_max_length,
   output logic                               rsp_congested,
   output logic [CNT_W-1:0]                   rsp_free_count,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   // configuration registers
   logic [bpc_pkg::ADDR_W-1:0]  area_base_ff;
   logic [bpc_pkg::LEN_W-1:0]   area_length_ff;
   logic [bpc_pkg::SHIFT_W-1:0] align_shift_ff;
   logic [bpc_pkg::REQ_W-1:0]   cell_request_ff;

   // queue and sequencer state
   bpc_pkg::fsm_type            state_ff, state_in;
   logic [IDX_W-1:0]            head_ff, head_in;
   logic [IDX_W-1:0]            tail_ff, tail_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        cong_ff, cong_in;
   logic [bpc_pkg::CELL_W-1:0]  cell_size_ff, cell_size_in;
   logic [bpc_pkg::LEN_W-1:0]   remain_ff, remain_in;
   logic [bpc_pkg::ADDR_W-1:0]  fill_addr_ff, fill_addr_in;
   logic [CNT_W-1:0]            fill_cnt_ff, fill_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bpc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                        addr_sel_ff, addr_sel_in;

   // carve front end
   logic [bpc_pkg::ADDR_W-1:0]  align_m1;
   logic [bpc_pkg::ADDR_W-1:0]  align_mask;
   logic [bpc_pkg::ADDR_W:0]    base_sum;
   logic [bpc_pkg::ADDR_W-1:0]  base_al;
   logic [bpc_pkg::CELL_W-1:0]  cell_sum;
   logic [bpc_pkg::CELL_W-1:0]  cell_al;
   logic [bpc_pkg::OFFS_W-1:0]  offset;
   logic                        carve_reject;

   // fill step
   logic                        fill_fits;
   logic                        fill_full;

   // RAM ports
   logic                        accept;
   logic                        ram_wr_en;
   logic [IDX_W-1:0]            ram_wr_addr;
   logic [bpc_pkg::ADDR_W-1:0]  ram_wr_data;
   logic                        ram_rd_en;
   logic [bpc_pkg::ADDR_W-1:0]  ram_rd_data;

   assign busy   = (state_ff == bpc_pkg::FSM_FILL);
   assign accept = start && !busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         area_base_ff    <= '0;
         area_length_ff  <= '0;
         align_shift_ff  <= bpc_pkg::ALIGN_SHIFT_RST;
         cell_request_ff <= bpc_pkg::CELL_REQUEST_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bpc_pkg::CSR_AREA_BASE: begin
               area_base_ff <= csr_wr_data;
            end
            bpc_pkg::CSR_AREA_LENGTH: begin
               area_length_ff <= csr_wr_data[bpc_pkg::LEN_W-1:0];
            end
            bpc_pkg::CSR_ALIGN_SHIFT: begin
               align_shift_ff <= csr_wr_data[bpc_pkg::SHIFT_W-1:0];
            end
            bpc_pkg::CSR_CELL_REQUEST: begin
               cell_request_ff <= csr_wr_data[bpc_pkg::REQ_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // rounding of base and cell size to the alignment
   assign align_m1   = (bpc_pkg::ADDR_W'(1) << align_shift_ff) - bpc_pkg::ADDR_W'(1);
   assign align_mask = ~align_m1;
   assign base_sum   = {1'b0, area_base_ff} + {1'b0, align_m1};
   assign base_al    = base_sum[bpc_pkg::ADDR_W-1:0] & align_mask;
   assign cell_sum   = {1'b0, cell_request_ff} + align_m1[bpc_pkg::CELL_W-1:0];
   assign cell_al    = cell_sum & align_mask[bpc_pkg::CELL_W-1:0];
   // offset is below 2^15, so the low half of the difference is exact
   assign offset     = base_al[bpc_pkg::OFFS_W-1:0] - area_base_ff[bpc_pkg::OFFS_W-1:0];
   assign carve_reject = (cell_al == '0) ||
                         ({{(bpc_pkg::LEN_W-bpc_pkg::OFFS_W){1'b0}}, offset} > area_length_ff);

   // one cell per fill cycle while it fits and the queue has room
   assign fill_fits = {{(bpc_pkg::LEN_W-bpc_pkg::CELL_W){1'b0}}, cell_size_ff} <= remain_ff;
   assign fill_full = (fill_cnt_ff == CNT_W'(MAX_CELLS));

   // RAM port selection: fill writes by cell number, free writes at the tail
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = req_free_address;
      ram_rd_en   = accept && (req_cmd == bpc_pkg::CMD_GET) && (count_ff != '0);
      if (busy) begin
         ram_wr_en   = fill_fits && !fill_full;
         ram_wr_addr = fill_cnt_ff[IDX_W-1:0];
         ram_wr_data = fill_addr_ff;
      end else if (accept && (req_cmd == bpc_pkg::CMD_FREE) &&
                   (count_ff != CNT_W'(MAX_CELLS))) begin
         ram_wr_en = 1'b1;
      end
   end

   // command handling and carve sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cong_in       = cong_ff;
      cell_size_in  = cell_size_ff;
      remain_in     = remain_ff;
      fill_addr_in  = fill_addr_ff;
      fill_cnt_in   = fill_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      addr_sel_in   = 1'b0;

      unique case (state_ff)
         bpc_pkg::FSM_IDLE: begin
            if (accept) begin
               priority if (req_cmd == bpc_pkg::CMD_CARVE) begin
                  cell_size_in = cell_al;
                  head_in      = '0;
                  tail_in      = '0;
                  count_in     = '0;
                  if (carve_reject) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = bpc_pkg::STAT_TOO_FEW;
                  end else begin
                     state_in     = bpc_pkg::FSM_FILL;
                     remain_in    = area_length_ff -
                                    {{(bpc_pkg::LEN_W-bpc_pkg::OFFS_W){1'b0}}, offset};
                     fill_addr_in = base_al;
                     fill_cnt_in  = '0;
                  end
               end else if (req_cmd == bpc_pkg::CMD_GET) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpc_pkg::STAT_OK;
                  if (count_ff == '0) begin
                     rsp_status_in = bpc_pkg::STAT_NO_BUFFER;
                  end else begin
                     if (32'(count_ff) == CONGEST_LEVEL) begin
                        cong_in       = 1'b1;
                        rsp_status_in = bpc_pkg::STAT_CONGESTION;
                     end
                     addr_sel_in = 1'b1;
                     head_in     = (head_ff == IDX_W'(MAX_CELLS - 1)) ? '0 :
                                   head_ff + IDX_W'(1);
                     count_in    = count_ff - CNT_W'(1);
                  end
               end else if (req_cmd == bpc_pkg::CMD_FREE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpc_pkg::STAT_OK;
                  if (count_ff == CNT_W'(MAX_CELLS)) begin
                     rsp_status_in = bpc_pkg::STAT_POOL_FULL;
                  end else begin
                     tail_in  = (tail_ff == IDX_W'(MAX_CELLS - 1)) ? '0 :
                                tail_ff + IDX_W'(1);
                     count_in = count_ff + CNT_W'(1);
                     if (32'(count_ff) + 1 == UNCONGEST_LEVEL) begin
                        cong_in = 1'b0;
                     end
                  end
               end else begin
                  // unused command: no state change
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpc_pkg::STAT_OK;
               end
            end
         end
         bpc_pkg::FSM_FILL: begin
            if (fill_fits && !fill_full) begin
               remain_in    = remain_ff - {{(bpc_pkg::LEN_W-bpc_pkg::CELL_W){1'b0}},
                                           cell_size_ff};
               fill_addr_in = fill_addr_ff +
                              {{(bpc_pkg::ADDR_W-bpc_pkg::CELL_W){1'b0}}, cell_size_ff};
               fill_cnt_in  = fill_cnt_ff + CNT_W'(1);
            end else begin
               state_in     = bpc_pkg::FSM_IDLE;
               rsp_valid_in = 1'b1;
               if (32'(fill_cnt_ff) < UNCONGEST_LEVEL) begin
                  rsp_status_in = bpc_pkg::STAT_TOO_FEW;
               end else begin
                  rsp_status_in = bpc_pkg::STAT_OK;
                  count_in      = fill_cnt_ff;
                  tail_in       = fill_full ? '0 : fill_cnt_ff[IDX_W-1:0];
                  cong_in       = 1'b0;
               end
            end
         end
         default: begin
            state_in = bpc_pkg::FSM_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpc_pkg::FSM_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         cong_ff       <= 1'b0;
         cell_size_ff  <= '0;
         fill_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= bpc_pkg::STAT_OK;
         addr_sel_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         cong_ff       <= cong_in;
         cell_size_ff  <= cell_size_in;
         fill_cnt_ff   <= fill_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         addr_sel_ff   <= addr_sel_in;
      end
   end

   // fill datapath
   always_ff @(posedge clock) begin
      remain_ff    <= remain_in;
      fill_addr_ff <= fill_addr_in;
   end

   // free list storage
   bpc_ram #(
      .WIDTH (bpc_pkg::ADDR_W),
      .DEPTH (MAX_CELLS)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // response: state registers hold the post-command values for the strobe cycle
   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_buf_address    = addr_sel_ff ? ram_rd_data : '0;
   assign rsp_buf_max_length = cell_size_ff;
   assign rsp_congested      = cong_ff;
   assign rsp_free_count     = count_ff;

endmodule

/* bench/tb_buffer_pool_with_congestion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buffer_pool_with_congestion - self-checking bench for the buffer pool
// Drives carve, get and free commands with random idle gaps and checks every
// response field against a behavioural pool kept in a small scoreboard class.
// Directed cases cover reset values, empty and full queue, congestion set and
// clear, rejected carves, the cell cap and address wrap. Then random phases
// reprogram the area and run mixed traffic.
// ----------------------------------------------------------------------------
module tb_buffer_pool_with_congestion;

   localparam int POOL_DEPTH   = bpc_pkg::MAX_CELLS_DEF;
   localparam int CONGEST_AT   = bpc_pkg::CONGEST_LEVEL_DEF;
   localparam int UNCONGEST_AT = bpc_pkg::UNCONGEST_LEVEL_DEF;
   localparam int CNT_W        = $clog2(POOL_DEPTH + 1);
   localparam int ITEMS_TARGET = 1000;
   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_REPORTS  = 10;
   localparam int SETTLE_CYCLES = 4;
   // spare command code, answered with status OK but otherwise ignored
   localparam logic [bpc_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

   // one predicted response
   typedef struct {
      logic [bpc_pkg::STATUS_W-1:0] status;
      logic [bpc_pkg::ADDR_W-1:0]   buf_address;
      logic [bpc_pkg::CELL_W-1:0]   max_length;
      logic                         congested;
      logic [CNT_W-1:0]             free_count;
   } pool_outcome_type;

   // behavioural pool plus queue of outstanding responses
   class pool_tracker_type;
      logic [bpc_pkg::ADDR_W-1:0]  area_base;
      logic [bpc_pkg::LEN_W-1:0]   area_length;
      logic [bpc_pkg::SHIFT_W-1:0] align_shift;
      logic [bpc_pkg::REQ_W-1:0]   cell_request;
      logic [bpc_pkg::CELL_W-1:0]  cell_size;
      logic                        congested;
      logic [bpc_pkg::ADDR_W-1:0]  free_cells[$];
      logic [bpc_pkg::ADDR_W-1:0]  lent[$];
      pool_outcome_type            outcome_q[$];
      int                          mismatches;

      function new();
         area_base    = '0;
         area_length  = '0;
         align_shift  = bpc_pkg::ALIGN_SHIFT_RST;
         cell_request = bpc_pkg::CELL_REQUEST_RST;
         cell_size    = '0;
         congested    = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_reg(logic [bpc_pkg::CSR_IDX_W-1:0] idx,
                            logic [bpc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            bpc_pkg::CSR_AREA_BASE:    area_base    = data;
            bpc_pkg::CSR_AREA_LENGTH:  area_length  = data[bpc_pkg::LEN_W-1:0];
            bpc_pkg::CSR_ALIGN_SHIFT:  align_shift  = data[bpc_pkg::SHIFT_W-1:0];
            bpc_pkg::CSR_CELL_REQUEST: cell_request = data[bpc_pkg::REQ_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // split the area into aligned cells; the queue empties whatever happens
      function logic [bpc_pkg::STATUS_W-1:0] carve_area();
         logic [63:0] align, amask, base_al, offset, size64, n_cells, addr64;
         align   = 64'd1 << align_shift;
         amask   = ~(align - 64'd1);
         base_al = ({32'd0, area_base} + align - 64'd1) & amask;
         offset  = base_al - {32'd0, area_base};
         size64  = ({48'd0, cell_request} + align - 64'd1) & amask;
         cell_size = size64[bpc_pkg::CELL_W-1:0];
         free_cells.delete();
         if (cell_size == '0 || offset > {33'd0, area_length})
            return bpc_pkg::STAT_TOO_FEW;
         n_cells = ({33'd0, area_length} - offset) / {47'd0, cell_size};
         if (n_cells < UNCONGEST_AT)
            return bpc_pkg::STAT_TOO_FEW;
         if (n_cells > POOL_DEPTH)
            n_cells = POOL_DEPTH;
         for (longint i = 0; i < n_cells; i++) begin
            addr64 = base_al + i * {47'd0, cell_size};
            free_cells.push_back(addr64[bpc_pkg::ADDR_W-1:0]);
         end
         congested = 1'b0;
         return bpc_pkg::STAT_OK;
      endfunction

      // accepted command: update the pool and queue its response
      function void take_command(logic [bpc_pkg::CMD_W-1:0] cmd,
                                 logic [bpc_pkg::ADDR_W-1:0] addr);
         pool_outcome_type o;
         o.status      = bpc_pkg::STAT_OK;
         o.buf_address = '0;
         case (cmd)
            bpc_pkg::CMD_CARVE: o.status = carve_area();
            bpc_pkg::CMD_GET: begin
               if (free_cells.size() == 0) begin
                  o.status = bpc_pkg::STAT_NO_BUFFER;
               end else begin
                  if (free_cells.size() == CONGEST_AT) begin
                     congested = 1'b1;
                     o.status  = bpc_pkg::STAT_CONGESTION;
                  end
                  o.buf_address = free_cells.pop_front();
                  lent.push_back(o.buf_address);
                  if (lent.size() > 2 * POOL_DEPTH)
                     void'(lent.pop_front());
               end
            end
            bpc_pkg::CMD_FREE: begin
               if (free_cells.size() >= POOL_DEPTH) begin
                  o.status = bpc_pkg::STAT_POOL_FULL;
               end else begin
                  free_cells.push_back(addr);
                  if (free_cells.size() == UNCONGEST_AT)
                     congested = 1'b0;
               end
            end
            default: ;
         endcase
         o.max_length = cell_size;
         o.congested  = congested;
         o.free_count = CNT_W'(free_cells.size());
         outcome_q.push_back(o);
      endfunction

      // compare one response with the oldest prediction
      function void check_response(logic [bpc_pkg::STATUS_W-1:0] status,
                                   logic [bpc_pkg::ADDR_W-1:0] addr,
                                   logic [bpc_pkg::CELL_W-1:0] max_len, logic cong,
                                   logic [CNT_W-1:0] count);
         pool_outcome_type o;
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with no command outstanding (status %0d)",
                        $realtime, status);
            return;
         end
         o = outcome_q.pop_front();
         if (status !== o.status || addr !== o.buf_address || max_len !== o.max_length ||
             cong !== o.congested || count !== o.free_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: mismatch exp status %0d addr %h len %0d cong %0d count %0d",
                        $realtime, o.status, o.buf_address, o.max_length, o.congested,
                        o.free_count);
               $display("   got status %0d addr %h len %0d cong %0d count %0d",
                        status, addr, max_len, cong, count);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [bpc_pkg::CMD_W-1:0]      req_cmd = bpc_pkg::CMD_GET;
   logic [bpc_pkg::ADDR_W-1:0]     req_free_address = '0;
   logic                           rsp_strobe;
   logic [bpc_pkg::STATUS_W-1:0]   rsp_status;
   logic [bpc_pkg::ADDR_W-1:0]     rsp_buf_address;
   logic [bpc_pkg::CELL_W-1:0]     rsp_buf_max_length;
   logic                           rsp_congested;
   logic [CNT_W-1:0]               rsp_free_count;
   logic                           csr_wr_en = 1'b0;
   logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index = bpc_pkg::CSR_AREA_BASE;
   logic [bpc_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   pool_tracker_type tracker;
   int  items_sent = 0;
   int  cycle_count = 0;
   bit  steady = 1'b0;

   buffer_pool_with_congestion u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_free_address   (req_free_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_buf_address    (rsp_buf_address),
      .rsp_buf_max_length (rsp_buf_max_length),
      .rsp_congested      (rsp_congested),
      .rsp_free_count     (rsp_free_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // monitor: command transfers and responses, sampled before the edge updates
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            tracker.check_response(rsp_status, rsp_buf_address, rsp_buf_max_length,
                                   rsp_congested, rsp_free_count);
         if (start && !busy)
            tracker.take_command(req_cmd, req_free_address);
      end
   end

   // present one command, after a random gap, and hold it until taken
   task automatic send(input logic [bpc_pkg::CMD_W-1:0] cmd,
                       input logic [bpc_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(0, 99) < 37) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_free_address <= addr;
      do @(posedge clock); while (busy);
      if (cmd != CMD_NONE)
         items_sent++;
   endtask

   // stop sending and wait until every response is in and the block is idle
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers, one per cycle; call only while idle
   task automatic program_area(input logic [31:0] base, input logic [31:0] len,
                               input logic [31:0] shift, input logic [31:0] req);
      logic [bpc_pkg::CSR_DATA_W-1:0] vals[4];
      logic [bpc_pkg::CSR_IDX_W-1:0]  idx[4];
      vals = '{base, len, shift, req};
      idx  = '{bpc_pkg::CSR_AREA_BASE, bpc_pkg::CSR_AREA_LENGTH,
               bpc_pkg::CSR_ALIGN_SHIFT, bpc_pkg::CSR_CELL_REQUEST};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[i];
         csr_wr_data <= vals[i];
         tracker.set_reg(idx[i], vals[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // free a cell handed out earlier, now and then a random address
   task automatic free_some();
      int pick;
      if (tracker.lent.size() != 0 && $urandom_range(0, 9) != 0) begin
         pick = $urandom_range(0, tracker.lent.size() - 1);
         send(bpc_pkg::CMD_FREE, tracker.lent[pick]);
         tracker.lent.delete(pick);
      end else begin
         send(bpc_pkg::CMD_FREE, $urandom);
      end
   endtask

   // pick an area for one random phase, mostly small pools
   task automatic random_area();
      logic [63:0] align, cell_sz, len;
      logic [31:0] base, shift, req;
      int r;
      r = $urandom_range(0, 9);
      shift = (r == 0) ? 0 : (r == 1) ? 12 : $urandom_range(0, 12);
      r = $urandom_range(0, 19);
      req = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : (r == 2) ? $urandom_range(0, 65535)
            : $urandom_range(1, 3000);
      r = $urandom_range(0, 9);
      base = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'd0 : $urandom;
      align   = 64'd1 << shift;
      cell_sz = ((req + align - 64'd1) >> shift) << shift;
      r = $urandom_range(0, 19);
      if (r == 0)
         len = 0;
      else if (r == 1)
         len = 64'h7FFF_FFFF;
      else if (r == 2)
         len = $urandom_range(0, 32'h7FFF_FFFF);
      else
         len = $urandom_range(0, 30) * cell_sz + $urandom_range(0, 8191);
      if (len > 64'h7FFF_FFFF)
         len = 64'h7FFF_FFFF;
      program_area(base, len[31:0], shift, req);
   endtask

   initial begin
      int phase, n_ops, p_get, r;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: empty pool, frees to an uncarved queue, last cell's get congests
      send(bpc_pkg::CMD_GET, 32'd0);
      send(bpc_pkg::CMD_FREE, 32'hFFFF_FFFF);
      send(bpc_pkg::CMD_FREE, 32'h0000_0000);
      send(CMD_NONE, 32'hA5A5_5A5A);
      send(bpc_pkg::CMD_GET, 32'd0);
      send(bpc_pkg::CMD_GET, 32'd0);
      send(bpc_pkg::CMD_GET, 32'd0);
      // default registers give a zero length area: too few cells
      send(bpc_pkg::CMD_CARVE, 32'd0);
      settle();
      // zero cell size
      program_area(32'd0, 32'd4096, 32'd2, 32'd0);
      send(bpc_pkg::CMD_CARVE, 32'd0);
      settle();
      // aligned base past the end of the area
      program_area(32'h0000_1001, 32'd100, 32'd12, 32'd100);
      send(bpc_pkg::CMD_CARVE, 32'd0);
      settle();
      // two cells only
      program_area(32'd0, 32'd2, 32'd0, 32'd1);
      send(bpc_pkg::CMD_CARVE, 32'd0);
      settle();
      // exactly three cells: drain into congestion, refill to clear it
      program_area(32'd0, 32'd3, 32'd0, 32'd1);
      send(bpc_pkg::CMD_CARVE, 32'd0);
      repeat (4) send(bpc_pkg::CMD_GET, 32'd0);
      send(bpc_pkg::CMD_FREE, 32'h0000_0002);
      send(bpc_pkg::CMD_FREE, 32'h8000_0000);
      send(bpc_pkg::CMD_FREE, 32'h7FFF_FFFF);
      settle();
      // huge area capped at the queue depth, then a free into the full queue
      program_area(32'd0, 32'h7FFF_FFFF, 32'd0, 32'hFFFF);
      send(bpc_pkg::CMD_CARVE, 32'd0);
      send(bpc_pkg::CMD_FREE, 32'h1234_5678);
      send(bpc_pkg::CMD_GET, 32'd0);
      settle();
      // cell addresses wrap past the top of the address space
      program_area(32'hFFFF_FF00, 32'd1280, 32'd8, 32'd64);
      send(bpc_pkg::CMD_CARVE, 32'd0);
      repeat (3) send(bpc_pkg::CMD_GET, 32'd0);
      settle();
      // largest aligned cell
      program_area(32'd0, 32'd69632 * 4, 32'd12, 32'hFFFF);
      send(bpc_pkg::CMD_CARVE, 32'd0);
      send(bpc_pkg::CMD_GET, 32'd0);

      // random phases: new area, carve, then mixed traffic
      phase = 0;
      while (items_sent < ITEMS_TARGET) begin
         settle();
         steady = (phase >= 8 && phase < 13);
         random_area();
         send(bpc_pkg::CMD_CARVE, 32'd0);
         n_ops = $urandom_range(15, 60);
         r = $urandom_range(0, 2);
         p_get = (r == 0) ? 25 : (r == 1) ? 50 : 75;
         for (int i = 0; i < n_ops; i++) begin
            // hold off mid phase until the pool has answered everything
            if (phase == 3 && i == n_ops / 2)
               settle();
            r = $urandom_range(0, 99);
            if (r < 2)
               send(CMD_NONE, $urandom);
            else if (r < 5)
               send(bpc_pkg::CMD_CARVE, $urandom);
            else if ($urandom_range(0, 99) < p_get)
               send(bpc_pkg::CMD_GET, $urandom);
            else
               free_some();
         end
         phase++;
      end

      settle();
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
